@@ design/rsr_pkg.sv @@
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types, constants and helpers for the reference-counted slot registry.
// ----------------------------------------------------------------------------
package rsr_pkg;

    localparam int SLOT_W    = 12;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int FRESH_W   = SLOT_W + 1;
    localparam int ISSUED_W  = 31;
    localparam int WORD_W    = 64;
    localparam int BAL_W     = 32;
    localparam int KIND_W    = 3;
    localparam int STRIDE_W  = 4;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [BAL_W-1:0] BALANCE_BIAS = 32'h8000_0000;

    // Input kind codes as they arrive on the stream
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RETAIN  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEAL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FREE    = 3'd4;

    // Classified operation; NOP covers unknown kinds and a free of slot zero
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ALLOC,
        OP_RETAIN,
        OP_RELEASE,
        OP_SEAL,
        OP_FREE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   slot;
        logic                start_sealed;
        logic [ISSUED_W-1:0] issued;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t item;
    } q_head_t;

    // Fresh slot scatter: with a power-of-two stride the (f % cols) * stride
    // + f / cols mapping is a left rotation of the slot number by log2(stride).
    // Strides beyond SLOTS saturate, and rotating by SLOT_W is the identity.
    function automatic logic [SLOT_W-1:0] fresh_slot(
        input logic [SLOT_W-1:0]   f,
        input logic [STRIDE_W-1:0] lg
    );
        logic [STRIDE_W-1:0]   lg_sat;
        logic [2*SLOT_W-1:0]   dbl;
        begin
            lg_sat = (lg > STRIDE_W'(SLOT_W)) ? STRIDE_W'(SLOT_W) : lg;
            dbl    = {f, f} << lg_sat;
            return dbl[2*SLOT_W-1:SLOT_W];
        end
    endfunction

endpackage

@@ design/rsr_front.sv @@
// ----------------------------------------------------------------------------
// rsr_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rsr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rsr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [rsr_pkg::KIND_W-1:0]    s_axis_tuser,
    output rsr_pkg::q_head_t              q_head,
    input  logic                          q_pop
);
    import rsr_pkg::*;

    localparam int Q_DEPTH = 2;

    q_entry_t          q_mem [Q_DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;
    logic              pop;
    q_entry_t          entry;
    logic [SLOT_W-1:0] in_slot;

    assign in_slot = s_axis_tdata[SLOT_W-1:0];

    // classify
    always_comb
    begin
        entry.slot         = in_slot;
        entry.start_sealed = s_axis_tdata[SLOT_W];
        entry.issued       = s_axis_tdata[SLOT_W+ISSUED_W:SLOT_W+1];
        unique case (s_axis_tuser)
            KIND_ALLOC:   entry.op = OP_ALLOC;
            KIND_RETAIN:  entry.op = OP_RETAIN;
            KIND_RELEASE: entry.op = OP_RELEASE;
            KIND_SEAL:    entry.op = OP_SEAL;
            KIND_FREE:    entry.op = (in_slot != '0) ? OP_FREE : OP_NOP;
            default:      entry.op = OP_NOP;
        endcase
    end

    assign s_axis_tready = (count_reg != 2'(Q_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && (count_reg != 2'd0);

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

@@ design/rsr_back.sv @@
// ----------------------------------------------------------------------------
// rsr_back
// Executes queued operations against the slot memories; owns free list head,
// fresh counter, stride register and the result output register.
// ----------------------------------------------------------------------------
module rsr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rsr_pkg::STRIDE_W-1:0]   cfg_wdata,
    input  rsr_pkg::q_head_t               q_head,
    output logic                           q_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rsr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import rsr_pkg::*;

    typedef enum logic {
        ST_FETCH,
        ST_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic [STRIDE_W-1:0] stride_reg;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [FRESH_W-1:0]  fresh_reg, fresh_next;
    q_entry_t            cur_reg;

    // memories, read data registered
    logic [SLOT_W-1:0]   link_mem [SLOTS];
    logic [WORD_W-1:0]   ref_mem  [SLOTS];
    logic [SLOT_W-1:0]   link_rd_reg;
    logic [WORD_W-1:0]   ref_rd_reg;

    logic                ref_we;
    logic [SLOT_W-1:0]   ref_wa;
    logic [WORD_W-1:0]   ref_wd;
    logic                link_we;

    // done stage between execute and output
    logic                done_valid_reg, done_valid_next;
    logic                done_status_reg, done_status_next;
    logic [SLOT_W-1:0]   done_slot_reg, done_slot_next;
    logic [WORD_W-1:0]   done_word_reg, done_word_next;
    logic                done_check_reg, done_check_next;
    logic                done_move;
    logic                exec_go;
    logic                dead;

    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign q_pop     = (state_reg == ST_FETCH) && q_head.valid;
    assign done_move = done_valid_reg && (!out_valid_reg || m_axis_tready);
    assign exec_go   = (state_reg == ST_EXEC) && (!done_valid_reg || done_move);

    // sealed and balance equals issued plus bias
    assign dead = done_check_reg && done_word_reg[WORD_W-1] &&
                  (done_word_reg[BAL_W-1:0] ==
                   ({1'b0, done_word_reg[WORD_W-2:BAL_W]} + BALANCE_BIAS));

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        fresh_next       = fresh_reg;
        done_valid_next  = done_move ? 1'b0 : done_valid_reg;
        done_status_next = done_status_reg;
        done_slot_next   = done_slot_reg;
        done_word_next   = done_word_reg;
        done_check_next  = done_check_reg;
        ref_we           = 1'b0;
        ref_wa           = cur_reg.slot;
        ref_wd           = ref_rd_reg;
        link_we          = 1'b0;

        unique case (state_reg)
            ST_FETCH:
            begin
                if (q_head.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next       = ST_FETCH;
                    done_valid_next  = 1'b1;
                    done_status_next = 1'b0;
                    done_slot_next   = '0;
                    done_check_next  = 1'b0;
                    done_word_next   = ref_rd_reg;
                    unique case (cur_reg.op)
                        OP_ALLOC:
                        begin
                            ref_wd = {cur_reg.start_sealed, 30'd0, cur_reg.start_sealed,
                                      BALANCE_BIAS};
                            if (head_reg != '0)
                            begin
                                ref_we         = 1'b1;
                                ref_wa         = head_reg;
                                done_slot_next = head_reg;
                                head_next      = link_rd_reg;
                            end
                            else if (!fresh_reg[FRESH_W-1])
                            begin
                                ref_we         = 1'b1;
                                ref_wa         = fresh_slot(fresh_reg[SLOT_W-1:0], stride_reg);
                                done_slot_next = ref_wa;
                                fresh_next     = fresh_reg + FRESH_W'(1);
                            end
                            else
                            begin
                                done_status_next = 1'b1;
                            end
                        end
                        OP_RETAIN:
                        begin
                            ref_we = 1'b1;
                            ref_wd = ref_rd_reg - WORD_W'(1);
                        end
                        OP_RELEASE:
                        begin
                            ref_we          = 1'b1;
                            ref_wd          = ref_rd_reg + WORD_W'(1);
                            done_word_next  = ref_wd;
                            done_check_next = 1'b1;
                        end
                        OP_SEAL:
                        begin
                            ref_we          = 1'b1;
                            ref_wd          = {ref_rd_reg[WORD_W-1:BAL_W] +
                                               {1'b1, cur_reg.issued},
                                               ref_rd_reg[BAL_W-1:0]};
                            done_word_next  = ref_wd;
                            done_check_next = 1'b1;
                        end
                        OP_FREE:
                        begin
                            link_we   = 1'b1;
                            head_next = cur_reg.slot;
                        end
                        OP_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    // state machine, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FETCH;
            stride_reg     <= '0;
            head_reg       <= '0;
            fresh_reg      <= FRESH_W'(1);
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fresh_reg      <= fresh_next;
            done_valid_reg <= done_valid_next;
            if (cfg_we)
            begin
                stride_reg <= cfg_wdata;
            end
            if (done_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head.item;
        end
        done_status_reg <= done_status_next;
        done_slot_reg   <= done_slot_next;
        done_word_reg   <= done_word_next;
        done_check_reg  <= done_check_next;
        if (done_move)
        begin
            out_data_reg <= {2'b00, dead, done_slot_reg, done_status_reg};
        end
    end

    // reference word memory
    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (q_pop)
        begin
            ref_rd_reg <= ref_mem[q_head.item.slot];
        end
    end

    // free list link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[cur_reg.slot] <= head_reg;
        end
        if (q_pop)
        begin
            link_rd_reg <= link_mem[head_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ design/refcounted_slot_registry.sv @@
// ----------------------------------------------------------------------------
// refcounted_slot_registry
// Reference-counted slot registry: free list allocator with per-slot counts.
// ----------------------------------------------------------------------------
// Each accepted transaction produces exactly one result transaction. The
// back end takes each operation through fetch, then execute, as set by the
// read-modify-write of one entry in the synchronous slot memories, and takes
// no new operation until the last one has executed. From input acceptance to
// result valid a transaction passes fetch, execute into the done stage, then
// the output register. A two-entry queue decouples input acceptance from
// execution, and the output register lets execution continue while a result
// waits. There is no clearing pass after reset: both slot memories are
// undefined until written, and the free list and fresh counter alone decide
// which entries are live. stride_log2 is written through cfg_we/cfg_wdata;
// the user must do so only while the block is idle, which is not enforced.
module refcounted_slot_registry (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: stride_log2
    input  logic                           cfg_we,
    input  logic [rsr_pkg::STRIDE_W-1:0]   cfg_wdata,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [11:0] slot, [12] start_sealed, [43:13] issued_count, [47:44] zero
    input  logic [rsr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] kind
    input  logic [rsr_pkg::KIND_W-1:0]     s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] status, [12:1] granted_slot, [13] dead, [15:14] zero
    output logic [rsr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import rsr_pkg::*;

    q_head_t q_head;
    logic    q_pop;

    // front end: classify kinds and queue transactions
    rsr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    // back end: slot memories, free list, fresh issue, result register
    rsr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
